// File: rtl/aco_pkg.sv
package aco_pkg;

  localparam int NodesDefault = 64;
  localparam int NodeW = 6;
  localparam int DataW = 32;
  localparam int CfgIdxW = 3;

  localparam logic [31:0] Sat32 = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    OP_FILL   = 3'd0,
    OP_START  = 3'd1,
    OP_DEP    = 3'd2,
    OP_FINISH = 3'd3,
    OP_READ   = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    MODE_BASIC  = 2'd0,
    MODE_ELITE  = 2'd1,
    MODE_MAXMIN = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    REG_MODE  = 3'd0,
    REG_KEEP  = 3'd1,
    REG_NUM   = 3'd2,
    REG_ELITE = 3'd3,
    REG_TMAX  = 3'd4,
    REG_TMIN  = 3'd5
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SWEEP_RD,
    ST_SWEEP_MUL,
    ST_SWEEP_WR,
    ST_DIV,
    ST_ELITE,
    ST_DEP_RD,
    ST_DEP_WAIT,
    ST_DEP_WR,
    ST_READ_WAIT,
    ST_DONE
  } state_t;

  // Saturating 32-bit add.
  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? Sat32 : s[31:0];
  endfunction

endpackage

// File: rtl/aco_ram.sv
module aco_ram #(
  parameter int Width = 32,
  parameter int Depth = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // Single write port, registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/aco_divider.sv
module aco_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] numerator,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  // Restoring divider, two quotient bits per cycle over a 48-bit dividend.
  logic [47:0] dividend;
  logic [31:0] rem;
  logic [47:0] quo;
  logic [4:0]  count;
  logic        busy;
  logic [32:0] r1, r2;
  logic        q1, q2;

  always_comb begin
    r1 = {rem, dividend[47]};
    q1 = (r1 >= {1'b0, divisor});
    if (q1) begin
      r1 = r1 - {1'b0, divisor};
    end
    r2 = {r1[31:0], dividend[46]};
    q2 = (r2 >= {1'b0, divisor});
    if (q2) begin
      r2 = r2 - {1'b0, divisor};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= 5'd0;
        dividend <= {numerator, 16'h0};
        rem <= '0;
        quo <= '0;
      end else if (busy) begin
        // The partial remainder stays below the divisor, so 32 bits hold it.
        rem <= r2[31:0];
        dividend <= {dividend[45:0], 2'b00};
        quo <= {quo[45:0], q1, q2};
        count <= count + 5'd1;
        if (count == 5'd23) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Saturate quotients above 32 bits.
  assign quotient = (quo[47:32] != '0) ? aco_pkg::Sat32 : quo[31:0];

endmodule

// File: rtl/aco_pheromone_update.sv
// A read addresses the entry and returns it; a deposit runs the divider, then scales and
// writes back; fill, start and finish sweep every entry with a read, multiply and write step each;
// skipped deposits, finish outside max-min and unused opcodes go straight to the result.
// One request at a time; the next can be accepted in the cycle after the result leaves.
// Reset clears control state and loads register defaults; both stores stay
// undefined until filled or written and need no clearing pass.
module aco_pheromone_update #(
  parameter int NODES = aco_pkg::NodesDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  opcode,
  input  logic [5:0]  from_node,
  input  logic [5:0]  to_node,
  input  logic [31:0] path_length,
  input  logic        best_flag,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] entry_value,
  output logic        zero_length
);

  localparam int Cells = NODES * NODES;
  localparam int AddrW = $clog2(Cells);
  localparam int IdxW  = $clog2(NODES);
  localparam int CntW  = AddrW;

  // Configuration registers.
  logic [1:0]  update_mode;
  logic [15:0] keep_factor;
  logic [31:0] deposit_numerator;
  logic [15:0] boost_weight;
  logic [31:0] tau_max;
  logic [31:0] tau_min;

  always_ff @(posedge clk) begin
    if (rst) begin
      update_mode       <= 2'd0;
      keep_factor       <= 16'd58982;
      deposit_numerator <= 32'd65536;
      boost_weight      <= 16'd256;
      tau_max           <= 32'd65536;
      tau_min           <= 32'd655;
    end else if (cfg_we) begin
      case (aco_pkg::reg_idx_t'(cfg_index))
        aco_pkg::REG_MODE:  update_mode       <= cfg_data[1:0];
        aco_pkg::REG_KEEP:  keep_factor       <= cfg_data[15:0];
        aco_pkg::REG_NUM:   deposit_numerator <= cfg_data;
        aco_pkg::REG_ELITE: boost_weight      <= cfg_data[15:0];
        aco_pkg::REG_TMAX:  tau_max           <= cfg_data;
        aco_pkg::REG_TMIN:  tau_min           <= cfg_data;
        default: ;
      endcase
    end
  end

  // Request registers.
  aco_pkg::state_t state, state_next;
  logic [2:0]       op;
  logic [IdxW-1:0]  fr, to;
  logic             in_range;
  logic             best;
  logic [31:0]      len;
  logic [CntW-1:0]  cnt;
  logic [31:0]      pher_q, rem_q;
  logic [47:0]      prod;
  logic [31:0]      dep;
  logic [31:0]      res_value;
  logic             res_zero;
  logic             maxmin;

  assign maxmin = (update_mode == aco_pkg::MODE_MAXMIN);

  // Memory ports.
  logic             p_we, r_we;
  logic [AddrW-1:0] p_waddr, r_waddr, raddr;
  logic [31:0]      p_wdata, r_wdata, p_rdata, r_rdata;

  aco_ram #(.Width(aco_pkg::DataW), .Depth(Cells)) u_pher (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(raddr), .rdata(p_rdata)
  );

  aco_ram #(.Width(aco_pkg::DataW), .Depth(Cells)) u_remain (
    .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
    .raddr(raddr), .rdata(r_rdata)
  );

  // Divider for the deposit amount.
  logic        div_start, div_done;
  logic [31:0] div_q;

  aco_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .numerator(deposit_numerator),
    .divisor(len), .done(div_done), .quotient(div_q)
  );

  logic [AddrW-1:0] addr_ft, addr_tf, sweep_addr;
  assign addr_ft    = AddrW'(fr * NODES + to);
  assign addr_tf    = AddrW'(to * NODES + fr);
  assign sweep_addr = cnt;

  logic [31:0] evap, fin_sum, fin_val;
  assign evap    = prod[47:16];
  assign fin_sum = aco_pkg::sat_add(evap, rem_q);
  always_comb begin
    fin_val = (fin_sum < tau_min) ? tau_min : fin_sum;
    if (fin_val > tau_max) begin
      fin_val = tau_max;
    end
  end

  logic [31:0] dep_sum;
  assign dep_sum = aco_pkg::sat_add(maxmin ? rem_q : pher_q, dep);

  logic [48:0] elite_prod;
  assign elite_prod = dep * ({1'b0, 8'd0} + 17'd256 + {1'b0, boost_weight});

  logic last_cell;
  assign last_cell = (cnt == CntW'(Cells - 1));

  // Next state and memory control.
  always_comb begin
    state_next = state;
    in_ready   = (state == aco_pkg::ST_IDLE);
    out_valid  = (state == aco_pkg::ST_DONE);
    p_we = 1'b0; p_waddr = sweep_addr; p_wdata = '0;
    r_we = 1'b0; r_waddr = sweep_addr; r_wdata = '0;
    raddr = sweep_addr;
    div_start = 1'b0;
    case (state)
      aco_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (opcode)
            aco_pkg::OP_FILL, aco_pkg::OP_START, aco_pkg::OP_FINISH:
              state_next = aco_pkg::ST_SWEEP_RD;
            aco_pkg::OP_DEP:  state_next = aco_pkg::ST_DIV;
            aco_pkg::OP_READ: state_next = aco_pkg::ST_DEP_RD;
            default:          state_next = aco_pkg::ST_DONE;
          endcase
          if (opcode == aco_pkg::OP_FINISH && !maxmin) begin
            state_next = aco_pkg::ST_DONE;
          end
          if (opcode == aco_pkg::OP_DEP && path_length == '0) begin
            state_next = aco_pkg::ST_DONE;
          end
        end
      end
      aco_pkg::ST_SWEEP_RD: begin
        state_next = aco_pkg::ST_SWEEP_MUL;
      end
      aco_pkg::ST_SWEEP_MUL: begin
        state_next = aco_pkg::ST_SWEEP_WR;
      end
      aco_pkg::ST_SWEEP_WR: begin
        case (op)
          aco_pkg::OP_FILL: begin
            p_we = 1'b1; p_wdata = tau_max;
          end
          aco_pkg::OP_START: begin
            if (maxmin) begin
              r_we = 1'b1;
            end else begin
              p_we = 1'b1; p_wdata = evap;
            end
          end
          default: begin
            p_we = 1'b1; p_wdata = fin_val;
          end
        endcase
        state_next = last_cell ? aco_pkg::ST_DONE : aco_pkg::ST_SWEEP_RD;
      end
      aco_pkg::ST_DIV: begin
        if (div_done) begin
          state_next = aco_pkg::ST_ELITE;
        end
      end
      aco_pkg::ST_ELITE: begin
        state_next = aco_pkg::ST_DEP_RD;
      end
      aco_pkg::ST_DEP_RD: begin
        raddr = (op == aco_pkg::OP_READ) ? addr_ft : addr_tf;
        state_next = (op == aco_pkg::OP_READ) ? aco_pkg::ST_READ_WAIT
                                               : aco_pkg::ST_DEP_WAIT;
      end
      aco_pkg::ST_DEP_WAIT: begin
        raddr = addr_tf;
        state_next = aco_pkg::ST_DEP_WR;
      end
      aco_pkg::ST_DEP_WR: begin
        raddr = addr_tf;
        if (in_range && (!maxmin || best)) begin
          if (maxmin) begin
            r_we = 1'b1; r_waddr = addr_tf; r_wdata = dep_sum;
          end else begin
            p_we = 1'b1; p_waddr = addr_tf; p_wdata = dep_sum;
          end
        end
        // The mirrored entry is written on the following cycle.
        state_next = aco_pkg::ST_READ_WAIT;
      end
      aco_pkg::ST_READ_WAIT: begin
        raddr = addr_ft;
        if (op == aco_pkg::OP_DEP && in_range && (!maxmin || best)) begin
          if (maxmin) begin
            r_we = 1'b1; r_waddr = addr_ft; r_wdata = dep;
          end else begin
            p_we = 1'b1; p_waddr = addr_ft; p_wdata = dep;
          end
        end
        state_next = aco_pkg::ST_DONE;
      end
      aco_pkg::ST_DONE: begin
        if (out_ready) begin
          state_next = aco_pkg::ST_IDLE;
        end
      end
      default: state_next = aco_pkg::ST_IDLE;
    endcase
    if (state == aco_pkg::ST_IDLE && in_valid && opcode == aco_pkg::OP_DEP
        && path_length != '0) begin
      div_start = 1'b1;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= aco_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
    case (state)
      aco_pkg::ST_IDLE: begin
        op        <= opcode;
        fr        <= IdxW'(from_node);
        to        <= IdxW'(to_node);
        in_range  <= (32'(from_node) < NODES) && (32'(to_node) < NODES);
        best      <= best_flag;
        len       <= path_length;
        cnt       <= '0;
        res_value <= '0;
        res_zero  <= (opcode == aco_pkg::OP_DEP) && (path_length == '0);
      end
      aco_pkg::ST_SWEEP_MUL: begin
        prod   <= p_rdata * keep_factor;
        rem_q  <= r_rdata;
      end
      aco_pkg::ST_SWEEP_WR: begin
        cnt <= cnt + CntW'(1);
      end
      aco_pkg::ST_DIV: begin
        dep <= div_q;
      end
      aco_pkg::ST_ELITE: begin
        if (update_mode == aco_pkg::MODE_ELITE && best) begin
          dep <= (elite_prod[48:40] != '0) ? aco_pkg::Sat32 : elite_prod[39:8];
        end
      end
      aco_pkg::ST_DEP_WAIT: begin
        pher_q <= p_rdata;
        rem_q  <= r_rdata;
      end
      aco_pkg::ST_DEP_WR: begin
        dep <= dep_sum;
      end
      aco_pkg::ST_READ_WAIT: begin
        if (op == aco_pkg::OP_READ && in_range) begin
          res_value <= p_rdata;
        end
      end
      default: ;
    endcase
  end

  assign entry_value = res_value;
  assign zero_length = res_zero;

endmodule
